[design/shared_level_irq_dispatcher_macros.svh]
// assertion macros shared by the dispatcher modules
// each macro expects clk and rst_n in scope
`ifndef SHARED_LEVEL_IRQ_DISPATCHER_MACROS_SVH
`define SHARED_LEVEL_IRQ_DISPATCHER_MACROS_SVH

// same-cycle implication
`define SLID_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slid: same-cycle check failed");

// next-cycle implication
`define SLID_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slid: next-cycle check failed");

`endif

[design/slid_pkg.sv]
`default_nettype none

package slid_pkg;

    // sizes
    localparam int NUM_SOURCES = 14;
    localparam int SRC_W       = 4;
    localparam int REG_W       = 15;
    localparam int CFG_W       = 14;
    localparam int WORD_W      = 16;
    localparam int KIND_W      = 2;
    localparam int LEVEL_W     = 3;
    localparam int CNT_W       = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 5;
    localparam int IDX_W       = 3;

    // bits of the enable and request registers that can be sources
    localparam logic [REG_W-1:0] SRC_BITS =
        REG_W'(((1 << NUM_SOURCES) - 1) & ((1 << CFG_W) - 1));

    // set/clear select bit of a written word
    localparam int SETCLR_POS = WORD_W - 1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WR_ENABLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAISE      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DISPATCH   = 2'd3;

    // register indexes on the apb port
    localparam logic [IDX_W-1:0] REG_LEVEL1  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEVEL2  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL3  = 3'd2;
    localparam logic [IDX_W-1:0] REG_LEVEL4  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEVEL5  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEVEL6  = 3'd5;
    localparam logic [IDX_W-1:0] REG_HANDLER = 3'd6;

    // reset values of the level masks and handler bits
    localparam logic [CFG_W-1:0] LEVEL1_RST  = 14'd7;
    localparam logic [CFG_W-1:0] LEVEL2_RST  = 14'd8;
    localparam logic [CFG_W-1:0] LEVEL3_RST  = 14'd112;
    localparam logic [CFG_W-1:0] LEVEL4_RST  = 14'd1920;
    localparam logic [CFG_W-1:0] LEVEL5_RST  = 14'd6144;
    localparam logic [CFG_W-1:0] LEVEL6_RST  = 14'd8192;
    localparam logic [CFG_W-1:0] HANDLER_RST = 14'd0;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic emit;
    } slid_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } slid_sts_t;

    // set/clear style register update
    function automatic logic [REG_W-1:0] setclr(input logic [REG_W-1:0] cur,
                                                input logic [WORD_W-1:0] word);
        logic [REG_W-1:0] sel;
        sel = word[REG_W-1:0];
        if (word[SETCLR_POS])
        begin
            return cur | sel;
        end
        return cur & ~sel;
    endfunction

endpackage

`default_nettype wire

[design/slid_ctrl.sv]
`default_nettype none
`include "shared_level_irq_dispatcher_macros.svh"

module slid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output slid_pkg::slid_cmd_t cmd,
    input  slid_pkg::slid_sts_t sts
);
    import slid_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // sequencing: take one transaction, then emit its results one per cycle while the output slot is free or being read
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot occupancy
    assign out_valid_next = cmd.emit | (out_valid_reg & ~result_ready);
    assign result_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SLID_ASSERT_NEXT(a_load_starts_emit, cmd.load, state_reg == ST_EMIT)
    `SLID_ASSERT_NEXT(a_last_ends_item, cmd.emit && sts.last, state_reg == ST_IDLE && result_valid)
    `SLID_ASSERT_NEXT(a_valid_held, result_valid && !result_ready, result_valid)

endmodule

`default_nettype wire

[design/slid_dp.sv]
`default_nettype none
`include "shared_level_irq_dispatcher_macros.svh"

module slid_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slid_pkg::slid_cmd_t               cmd,
    output slid_pkg::slid_sts_t               sts,
    input  logic [slid_pkg::KIND_W-1:0]       kind,
    input  logic [slid_pkg::WORD_W-1:0]       write_bits,
    input  logic [slid_pkg::LEVEL_W-1:0]      level,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slid_pkg::ADDR_W-1:0]       paddr,
    input  logic [slid_pkg::DATA_W-1:0]       pwdata,
    output logic [slid_pkg::DATA_W-1:0]       prdata,
    output logic [slid_pkg::SRC_W-1:0]        source,
    output logic                              serviced,
    output logic                              spurious,
    output logic                              none_active,
    output logic                              last,
    output logic [slid_pkg::REG_W-1:0]        enable_now,
    output logic [slid_pkg::REG_W-1:0]        request_now,
    output logic [slid_pkg::CNT_W-1:0]        spurious_count
);
    import slid_pkg::*;

    logic [CFG_W-1:0]       lvl1_reg;
    logic [CFG_W-1:0]       lvl2_reg;
    logic [CFG_W-1:0]       lvl3_reg;
    logic [CFG_W-1:0]       lvl4_reg;
    logic [CFG_W-1:0]       lvl5_reg;
    logic [CFG_W-1:0]       lvl6_reg;
    logic [CFG_W-1:0]       handler_reg;
    logic [REG_W-1:0]       enable_reg;
    logic [REG_W-1:0]       enable_next;
    logic [REG_W-1:0]       request_reg;
    logic [REG_W-1:0]       request_next;
    logic [CNT_W-1:0]       spur_total_reg;
    logic [CNT_W-1:0]       spur_total_next;
    logic [NUM_SOURCES-1:0] act_reg;
    logic [NUM_SOURCES-1:0] act_next;

    logic [SRC_W-1:0]       source_reg;
    logic                   serviced_reg;
    logic                   spurious_reg;
    logic                   none_reg;
    logic                   last_reg;
    logic [REG_W-1:0]       enable_now_reg;
    logic [REG_W-1:0]       request_now_reg;
    logic [CNT_W-1:0]       count_now_reg;

    logic                   cfg_wr;
    logic [IDX_W-1:0]       cfg_idx;
    logic [CFG_W-1:0]       cfg_val;
    logic [CFG_W-1:0]       level_mask;
    logic [NUM_SOURCES-1:0] dispatch_set;
    logic [NUM_SOURCES-1:0] low_bit;
    logic [NUM_SOURCES-1:0] rest;
    logic [REG_W-1:0]       low_ext;
    logic [SRC_W-1:0]       src_idx;
    logic                   act_empty;
    logic                   has_handler;
    logic                   drop;
    logic [REG_W-1:0]       en_emit;
    logic [REG_W-1:0]       req_emit;
    logic [CNT_W-1:0]       cnt_emit;

    // apb decode
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_val = pwdata[CFG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl1_reg    <= LEVEL1_RST;
            lvl2_reg    <= LEVEL2_RST;
            lvl3_reg    <= LEVEL3_RST;
            lvl4_reg    <= LEVEL4_RST;
            lvl5_reg    <= LEVEL5_RST;
            lvl6_reg    <= LEVEL6_RST;
            handler_reg <= HANDLER_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_LEVEL1:  lvl1_reg    <= cfg_val;
                REG_LEVEL2:  lvl2_reg    <= cfg_val;
                REG_LEVEL3:  lvl3_reg    <= cfg_val;
                REG_LEVEL4:  lvl4_reg    <= cfg_val;
                REG_LEVEL5:  lvl5_reg    <= cfg_val;
                REG_LEVEL6:  lvl6_reg    <= cfg_val;
                REG_HANDLER: handler_reg <= cfg_val;
                default:     ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_LEVEL1:  prdata = DATA_W'(lvl1_reg);
            REG_LEVEL2:  prdata = DATA_W'(lvl2_reg);
            REG_LEVEL3:  prdata = DATA_W'(lvl3_reg);
            REG_LEVEL4:  prdata = DATA_W'(lvl4_reg);
            REG_LEVEL5:  prdata = DATA_W'(lvl5_reg);
            REG_LEVEL6:  prdata = DATA_W'(lvl6_reg);
            REG_HANDLER: prdata = DATA_W'(handler_reg);
            default:     prdata = '0;
        endcase
    end

    // source mask of the dispatched level, levels zero and seven have none
    always_comb
    begin
        case (level)
            3'd1:    level_mask = lvl1_reg;
            3'd2:    level_mask = lvl2_reg;
            3'd3:    level_mask = lvl3_reg;
            3'd4:    level_mask = lvl4_reg;
            3'd5:    level_mask = lvl5_reg;
            3'd6:    level_mask = lvl6_reg;
            default: level_mask = '0;
        endcase
    end

    assign dispatch_set = NUM_SOURCES'(request_reg & enable_reg &
                                       REG_W'(level_mask) & SRC_BITS);

    // register writes and snapshot of the active set at accept
    always_comb
    begin
        enable_next  = enable_reg;
        request_next = request_reg;
        act_next     = '0;
        case (kind)
            KIND_WR_ENABLE:  enable_next  = setclr(enable_reg, write_bits);
            KIND_WR_REQUEST: request_next = setclr(request_reg, write_bits);
            KIND_RAISE:      request_next = request_reg | (write_bits[REG_W-1:0] & SRC_BITS);
            KIND_DISPATCH:   act_next     = dispatch_set;
            default:         ;
        endcase
    end

    // lowest active source
    assign low_bit   = act_reg & (~act_reg + NUM_SOURCES'(1));
    assign rest      = act_reg & ~low_bit;
    assign low_ext   = REG_W'(low_bit);
    assign act_empty = (act_reg == '0);

    always_comb
    begin
        src_idx = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (low_bit[i])
            begin
                src_idx = src_idx | SRC_W'(i);
            end
        end
    end

    // spurious shut-off
    assign has_handler = |(REG_W'(handler_reg) & low_ext);
    assign drop        = !act_empty && !has_handler;
    assign en_emit     = drop ? (enable_reg & ~low_ext) : enable_reg;
    assign req_emit    = drop ? (request_reg & ~low_ext) : request_reg;
    assign cnt_emit    = spur_total_reg + CNT_W'(drop);

    assign sts.last = (rest == '0);

    always_comb
    begin
        spur_total_next = spur_total_reg;
        if (cmd.emit)
        begin
            spur_total_next = cnt_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= '0;
            request_reg    <= '0;
            spur_total_reg <= '0;
            act_reg        <= '0;
        end
        else
        begin
            spur_total_reg <= spur_total_next;
            if (cmd.load)
            begin
                enable_reg  <= enable_next;
                request_reg <= request_next;
                act_reg     <= act_next;
            end
            else if (cmd.emit)
            begin
                enable_reg  <= en_emit;
                request_reg <= req_emit;
                act_reg     <= rest;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            source_reg      <= src_idx;
            serviced_reg    <= !act_empty && has_handler;
            spurious_reg    <= drop;
            none_reg        <= act_empty;
            last_reg        <= sts.last;
            enable_now_reg  <= en_emit;
            request_now_reg <= req_emit;
            count_now_reg   <= cnt_emit;
        end
    end

    assign source         = source_reg;
    assign serviced       = serviced_reg;
    assign spurious       = spurious_reg;
    assign none_active    = none_reg;
    assign last           = last_reg;
    assign enable_now     = enable_now_reg;
    assign request_now    = request_now_reg;
    assign spurious_count = count_now_reg;

    `SLID_ASSERT_NEXT(a_empty_gives_none, cmd.emit && act_empty, none_reg && last_reg)
    `SLID_ASSERT_NEXT(a_one_flag, cmd.emit && !act_empty, !none_reg && (serviced_reg != spurious_reg))
    `SLID_ASSERT_IMPL(a_count_on_emit, !$stable(spur_total_reg), $past(cmd.emit))

endmodule

`default_nettype wire

[design/shared_level_irq_dispatcher.sv]
// a transaction is loaded in the idle state; the emit state then registers its first result
// each transaction emits one result per cycle while the output slot is free or being read:
// register writes and raises emit one result, a dispatch emits 1 to 14 results
// a new transaction is taken while the last result still waits in the output register
// reset: rst_n async active low; enable, request and spurious count clear, level masks
// and handler bits take their defaults; no clearing pass
`default_nettype none

module shared_level_irq_dispatcher (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [slid_pkg::KIND_W-1:0]      kind,
    input  logic [slid_pkg::WORD_W-1:0]      write_bits,
    input  logic [slid_pkg::LEVEL_W-1:0]     level,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [slid_pkg::SRC_W-1:0]       source,
    output logic                             serviced,
    output logic                             spurious,
    output logic                             none_active,
    output logic                             last,
    output logic [slid_pkg::REG_W-1:0]       enable_now,
    output logic [slid_pkg::REG_W-1:0]       request_now,
    output logic [slid_pkg::CNT_W-1:0]       spurious_count,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slid_pkg::ADDR_W-1:0]      paddr,
    input  logic [slid_pkg::DATA_W-1:0]      pwdata,
    output logic [slid_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import slid_pkg::*;

    slid_cmd_t cmd;
    slid_sts_t sts;

    // no wait states on the apb port
    assign pready = 1'b1;

    // controller
    slid_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    // datapath
    slid_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .write_bits     (write_bits),
        .level          (level),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .source         (source),
        .serviced       (serviced),
        .spurious       (spurious),
        .none_active    (none_active),
        .last           (last),
        .enable_now     (enable_now),
        .request_now    (request_now),
        .spurious_count (spurious_count)
    );

endmodule

`default_nettype wire

[sim/tb_shared_level_irq_dispatcher.sv]
`timescale 1ns / 1ps

module tb_shared_level_irq_dispatcher;

    import slid_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int RAND_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 64;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  bits;
        logic [LEVEL_W-1:0] level;
    } irq_item_t;

    typedef struct packed {
        logic [SRC_W-1:0] source;
        logic             serviced;
        logic             spurious;
        logic             none_active;
        logic             last;
        logic [REG_W-1:0] enable_now;
        logic [REG_W-1:0] request_now;
        logic [CNT_W-1:0] spurious_count;
    } irq_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [KIND_W-1:0] kind = '0;
    logic [WORD_W-1:0] write_bits = '0;
    logic [LEVEL_W-1:0] level = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [SRC_W-1:0] source;
    logic serviced;
    logic spurious;
    logic none_active;
    logic last;
    logic [REG_W-1:0] enable_now;
    logic [REG_W-1:0] request_now;
    logic [CNT_W-1:0] spurious_count;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // model state of the controller
    logic [CFG_W-1:0] level_mask [0:7];
    logic [CFG_W-1:0] handler_mask;
    logic [REG_W-1:0] enable_model;
    logic [REG_W-1:0] request_model;
    logic [CNT_W-1:0] spurious_model;

    irq_item_t   pending_items [$];
    irq_report_t expected_reports [$];
    irq_report_t got_report;
    irq_report_t want_report;
    logic [DATA_W-1:0] cfg_words [0:6];

    int queued_total = 0;
    int accepted_total = 0;
    int err_count = 0;
    int shown_count = 0;
    int cycle_count = 0;
    int idle_rate = 0;
    int gap_left = 0;
    int stall_left = 0;
    logic item_taken = 1'b0;

    shared_level_irq_dispatcher uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .kind           (kind),
        .write_bits     (write_bits),
        .level          (level),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .source         (source),
        .serviced       (serviced),
        .spurious       (spurious),
        .none_active    (none_active),
        .last           (last),
        .enable_now     (enable_now),
        .request_now    (request_now),
        .spurious_count (spurious_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    function automatic string fmt_report(input irq_report_t r);
        return $sformatf("src=%0d serv=%0b spur=%0b none=%0b last=%0b en=%h req=%h cnt=%0d",
                         r.source, r.serviced, r.spurious, r.none_active, r.last,
                         r.enable_now, r.request_now, r.spurious_count);
    endfunction

    function automatic irq_report_t make_report(input logic [SRC_W-1:0] src,
                                                input logic serv, input logic spur,
                                                input logic none, input logic fin);
        irq_report_t r;
        r.source = src;
        r.serviced = serv;
        r.spurious = spur;
        r.none_active = none;
        r.last = fin;
        r.enable_now = enable_model;
        r.request_now = request_model;
        r.spurious_count = spurious_model;
        return r;
    endfunction

    // work out the reports one transaction causes and queue them
    function automatic void predict_dispatch(input irq_item_t it);
        logic [REG_W-1:0] sel;
        logic [CFG_W-1:0] active;
        logic fin;
        sel = it.bits[REG_W-1:0];
        case (it.kind)
            KIND_WR_ENABLE:
                enable_model = it.bits[WORD_W-1] ? (enable_model | sel) : (enable_model & ~sel);
            KIND_WR_REQUEST:
                request_model = it.bits[WORD_W-1] ? (request_model | sel)
                                                  : (request_model & ~sel);
            KIND_RAISE:
                request_model = request_model | {1'b0, it.bits[CFG_W-1:0]};
            default:
                ;
        endcase
        active = '0;
        if (it.kind == KIND_DISPATCH)
        begin
            active = request_model[CFG_W-1:0] & enable_model[CFG_W-1:0]
                     & level_mask[it.level];
        end
        if (active == '0)
        begin
            expected_reports.push_back(make_report('0, 1'b0, 1'b0, 1'b1, 1'b1));
            return;
        end
        // active set is a snapshot, spurious clears do not shrink it
        for (int s = 0; s < NUM_SOURCES; s++)
        begin
            if (active[s])
            begin
                fin = ((active >> (s + 1)) == '0);
                if (handler_mask[s])
                begin
                    expected_reports.push_back(make_report(SRC_W'(s), 1'b1, 1'b0, 1'b0, fin));
                end
                else
                begin
                    enable_model[s] = 1'b0;
                    request_model[s] = 1'b0;
                    spurious_model = spurious_model + 1;
                    expected_reports.push_back(make_report(SRC_W'(s), 1'b0, 1'b1, 1'b0, fin));
                end
            end
        end
    endfunction

    // monitor: checks reports, predicts accepted transactions, tracks register writes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                got_report = '{source, serviced, spurious, none_active, last,
                               enable_now, request_now, spurious_count};
                if (expected_reports.size() == 0)
                begin
                    err_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("unexpected result: %s", fmt_report(got_report));
                    end
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    if (got_report !== want_report)
                    begin
                        err_count++;
                        if (shown_count < 10)
                        begin
                            shown_count++;
                            $display("mismatch expected: %s", fmt_report(want_report));
                            $display("         actual:   %s", fmt_report(got_report));
                        end
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                predict_dispatch('{kind, write_bits, level});
                accepted_total++;
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[4:2] <= REG_LEVEL6)
                begin
                    level_mask[paddr[4:2] + 1] = pwdata[CFG_W-1:0];
                end
                else if (paddr[4:2] == REG_HANDLER)
                begin
                    handler_mask = pwdata[CFG_W-1:0];
                end
            end
            item_taken <= item_valid && item_ready;
        end
        else
        begin
            item_taken <= 1'b0;
        end
    end

    // driver: presents pending transactions with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                irq_item_t it;
                it = pending_items.pop_front();
                kind <= it.kind;
                write_bits <= it.bits;
                level <= it.level;
                item_valid <= 1'b1;
                if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1)
                begin
                    gap_left = $urandom_range(1, 9);
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_ready <= 1'b1;
            if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1)
            begin
                stall_left = $urandom_range(1, 9);
            end
        end
    end

    task automatic add_item(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] b,
                            input logic [LEVEL_W-1:0] l);
        pending_items.push_back('{k, b, l});
        queued_total++;
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_config();
        for (int i = 0; i <= REG_HANDLER; i++)
        begin
            apb_write(IDX_W'(i), cfg_words[i]);
        end
    endtask

    // wait until every transaction is taken and every report is back
    task automatic wait_idle();
        while (accepted_total != queued_total || expected_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        irq_item_t it;
        int pick;

        level_mask[0] = '0;
        level_mask[1] = LEVEL1_RST;
        level_mask[2] = LEVEL2_RST;
        level_mask[3] = LEVEL3_RST;
        level_mask[4] = LEVEL4_RST;
        level_mask[5] = LEVEL5_RST;
        level_mask[6] = LEVEL6_RST;
        level_mask[7] = '0;
        handler_mask = HANDLER_RST;
        enable_model = '0;
        request_model = '0;
        spurious_model = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // default wiring, no handlers: every active source goes spurious
        idle_rate = 3;
        add_item(KIND_DISPATCH, 16'h0000, 3'd0);
        add_item(KIND_DISPATCH, 16'hFFFF, 3'd7);
        add_item(KIND_WR_ENABLE, 16'hFFFF, 3'd0);
        add_item(KIND_RAISE, 16'hFFFF, 3'd7);
        add_item(KIND_WR_REQUEST, 16'hC000, 3'd2);
        for (int l = 1; l <= 6; l++)
        begin
            add_item(KIND_DISPATCH, 16'h5A5A, LEVEL_W'(l));
        end
        add_item(KIND_DISPATCH, 16'h0000, 3'd1);
        wait_idle();

        // every source on one level, all handled: longest dispatch
        for (int i = 0; i <= REG_LEVEL6; i++)
        begin
            cfg_words[i] = 32'hFFFF_FFFF;
        end
        cfg_words[REG_HANDLER] = 32'hFFFF_FFFF;
        load_config();
        apb_write(REG_UNMAPPED, 32'h0000_0000);
        add_item(KIND_WR_ENABLE, 16'hFFFF, 3'd0);
        add_item(KIND_RAISE, 16'hFFFF, 3'd0);
        add_item(KIND_DISPATCH, 16'h0000, 3'd6);
        wait_idle();

        // half the handlers gone: serviced and spurious mixed in one dispatch
        apb_write(REG_HANDLER, 32'hABCD_5555);
        add_item(KIND_DISPATCH, 16'hFFFF, 3'd3);
        add_item(KIND_DISPATCH, 16'h0000, 3'd3);
        add_item(KIND_WR_REQUEST, 16'h0000, 3'd0);
        add_item(KIND_WR_REQUEST, 16'h7FFF, 3'd0);
        add_item(KIND_WR_ENABLE, 16'h7FFF, 3'd0);
        add_item(KIND_DISPATCH, 16'h0000, 3'd2);
        add_item(KIND_RAISE, 16'h0000, 3'd0);
        wait_idle();

        // nothing wired anywhere
        for (int i = 0; i <= REG_HANDLER; i++)
        begin
            cfg_words[i] = 32'h0000_0000;
        end
        load_config();
        add_item(KIND_WR_ENABLE, 16'hFFFF, 3'd0);
        add_item(KIND_RAISE, 16'hFFFF, 3'd0);
        add_item(KIND_DISPATCH, 16'h0000, 3'd4);
        wait_idle();

        // random phases, each with its own wiring and idle pressure
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (int i = 0; i <= REG_LEVEL6; i++)
            begin
                cfg_words[i] = $urandom();
            end
            pick = $urandom_range(0, 3);
            cfg_words[REG_HANDLER] = (pick == 0) ? 32'h0 :
                                     (pick == 1) ? 32'hFFFF_FFFF : $urandom();
            load_config();
            case (ph)
                0: idle_rate = 2;
                1: idle_rate = 6;
                2: idle_rate = 0;
                3: idle_rate = 3;
                default: idle_rate = 0;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.bits = WORD_W'($urandom());
                it.level = LEVEL_W'($urandom_range(0, 7));
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    it.kind = KIND_WR_ENABLE;
                    // mostly set, since spurious sources keep switching themselves off
                    it.bits[WORD_W-1] = ($urandom_range(0, 3) != 0);
                end
                else if (pick < 35)
                begin
                    it.kind = KIND_WR_REQUEST;
                end
                else if (pick < 65)
                begin
                    it.kind = KIND_RAISE;
                end
                else
                begin
                    it.kind = KIND_DISPATCH;
                    if ($urandom_range(0, 9) != 0)
                    begin
                        it.level = LEVEL_W'($urandom_range(1, 6));
                    end
                end
                add_item(it.kind, it.bits, it.level);
            end
            wait_idle();
        end

        // trailing window for stray results
        repeat (40) @(posedge clk);
        if (err_count == 0 && expected_reports.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
